[rtl/sprite_blit_page_framebuffer_macros.svh]
// Assertion macros for the sprite blit page framebuffer.
`ifndef SPRITE_BLIT_PAGE_FRAMEBUFFER_MACROS_SVH
`define SPRITE_BLIT_PAGE_FRAMEBUFFER_MACROS_SVH
`ifndef SYNTHESIS
`define SPBFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SPBFB_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SPBFB_ASSERT(lbl, prop, msg)
`define SPBFB_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/spbfb_pkg.sv]
// Types and constants shared by the sprite blit page framebuffer.
package spbfb_pkg;

	localparam logic [1:0] FN_CLEAR = 2'd0;
	localparam logic [1:0] FN_BEGIN = 2'd1;
	localparam logic [1:0] FN_BLIT  = 2'd2;
	localparam logic [1:0] FN_READ  = 2'd3;

	localparam logic [7:0] MAX_SPRITE_COLS = 8'd128;

	// wide enough for any store index at the largest supported geometry
	localparam int ADDR_W = 12;
	localparam int POS_W  = 18;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] origin_x;
		logic [7:0] origin_y;
		logic [7:0] sprite_width;
		logic [7:0] sprite_byte;
		logic [9:0] read_address;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       clipped;
	} res_t;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_CLEAR,
		CMD_BLIT,
		CMD_READ
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] addr_hi;
		logic [7:0]        data_lo;
		logic [7:0]        data_hi;
		logic              spill;
		logic              clipped;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_CLEAR,
		BK_READ,
		BK_WR_LO,
		BK_RD_HI,
		BK_WR_HI
	} bk_state_t;

endpackage

[rtl/spbfb_front.sv]
// Front end: takes requests, tracks the sprite cursor, builds store commands.
module spbfb_front #(
	parameter int FRAME_BYTES     = 1024,
	parameter int DISPLAY_COLUMNS = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hold,
	input  logic                in_valid,
	output logic                in_ready,
	input  spbfb_pkg::req_t     in_data,
	input  spbfb_pkg::q_status_t q_stat,
	output logic                push,
	output spbfb_pkg::q_entry_t push_data
);

	logic [7:0] ox_q;
	logic [7:0] oy_q;
	logic [7:0] cols_q;
	logic [6:0] ccol_q;
	logic [8:0] crow_q;

	logic       valid_s1;
	logic [1:0] func_s1;
	logic [8:0] col_s1;
	logic [9:0] row_s1;
	logic [7:0] data_s1;
	logic [9:0] raddr_s1;

	logic                    acc;
	logic [7:0]              w_clamp;
	logic [7:0]              ccol_inc;
	logic [2:0]              shift;
	logic [15:0]             sh16;
	logic [spbfb_pkg::POS_W-1:0] pos;
	logic [spbfb_pkg::POS_W-1:0] pos_hi;
	logic                    col_off;
	logic                    pos_off;
	logic                    raddr_ok;

	assign acc      = in_valid & in_ready;
	assign in_ready = !hold && (!valid_s1 || !q_stat.full);
	assign push     = valid_s1 && !q_stat.full;
	assign ccol_inc = {1'b0, ccol_q} + 8'd1;

	always_comb begin
		if (in_data.sprite_width == 8'd0) begin
			w_clamp = 8'd1;
		end else if (in_data.sprite_width > spbfb_pkg::MAX_SPRITE_COLS) begin
			w_clamp = spbfb_pkg::MAX_SPRITE_COLS;
		end else begin
			w_clamp = in_data.sprite_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q   <= '0;
			oy_q   <= '0;
			cols_q <= 8'd1;
			ccol_q <= '0;
			crow_q <= '0;
		end else if (acc) begin
			unique case (in_data.func)
				spbfb_pkg::FN_BEGIN: begin
					ox_q   <= in_data.origin_x;
					oy_q   <= in_data.origin_y;
					cols_q <= w_clamp;
					ccol_q <= '0;
					crow_q <= '0;
				end
				spbfb_pkg::FN_BLIT: begin
					if (ccol_inc >= cols_q) begin
						ccol_q <= '0;
						crow_q <= crow_q + 9'd8;
					end else begin
						ccol_q <= ccol_inc[6:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_s1  <= in_data.func;
			col_s1   <= 9'(ox_q) + 9'(ccol_q);
			row_s1   <= 10'(oy_q) + 10'(crow_q);
			data_s1  <= in_data.sprite_byte;
			raddr_s1 <= in_data.read_address;
		end
	end

	assign shift    = row_s1[2:0];
	assign sh16     = {8'd0, data_s1} << shift;
	assign pos      = spbfb_pkg::POS_W'(row_s1[9:3]) * spbfb_pkg::POS_W'(DISPLAY_COLUMNS)
		+ spbfb_pkg::POS_W'(col_s1);
	assign pos_hi   = pos + spbfb_pkg::POS_W'(DISPLAY_COLUMNS);
	assign col_off  = spbfb_pkg::POS_W'(col_s1) >= spbfb_pkg::POS_W'(DISPLAY_COLUMNS);
	assign pos_off  = pos >= spbfb_pkg::POS_W'(FRAME_BYTES);
	assign raddr_ok = spbfb_pkg::POS_W'(raddr_s1) < spbfb_pkg::POS_W'(FRAME_BYTES);

	always_comb begin
		push_data         = '0;
		push_data.cmd     = spbfb_pkg::CMD_NOP;
		push_data.addr    = pos[spbfb_pkg::ADDR_W-1:0];
		push_data.addr_hi = pos_hi[spbfb_pkg::ADDR_W-1:0];
		push_data.data_lo = sh16[7:0];
		push_data.data_hi = sh16[15:8];
		push_data.spill   = (shift != 3'd0) && (pos_hi < spbfb_pkg::POS_W'(FRAME_BYTES));
		unique case (func_s1)
			spbfb_pkg::FN_CLEAR: begin
				push_data.cmd = spbfb_pkg::CMD_CLEAR;
			end
			spbfb_pkg::FN_BLIT: begin
				if (data_s1 != 8'd0) begin
					if (col_off || pos_off) begin
						push_data.clipped = 1'b1;
					end else begin
						push_data.cmd = spbfb_pkg::CMD_BLIT;
					end
				end
			end
			spbfb_pkg::FN_READ: begin
				push_data.addr = spbfb_pkg::ADDR_W'(raddr_s1);
				if (raddr_ok) begin
					push_data.cmd = spbfb_pkg::CMD_READ;
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/spbfb_queue.sv]
// Two-entry command queue between the front end and the store sequencer.
`include "sprite_blit_page_framebuffer_macros.svh"

module spbfb_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  spbfb_pkg::q_entry_t  push_data,
	input  logic                 pop,
	output spbfb_pkg::q_entry_t  head,
	output spbfb_pkg::q_status_t q_stat
);

	spbfb_pkg::q_entry_t ent_q [spbfb_pkg::Q_DEPTH];
	logic [spbfb_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [spbfb_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [spbfb_pkg::Q_CNT_W-1:0] cnt_q;

	assign head         = ent_q[rd_ptr_q];
	assign q_stat.full  = cnt_q == spbfb_pkg::Q_CNT_W'(spbfb_pkg::Q_DEPTH);
	assign q_stat.empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + spbfb_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + spbfb_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + spbfb_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - spbfb_pkg::Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	`SPBFB_NEVER(a_q_push_full, push && q_stat.full, "push into full queue")
	`SPBFB_NEVER(a_q_pop_empty, pop && q_stat.empty, "pop from empty queue")
	`SPBFB_ASSERT(a_q_cnt_ptr, q_stat.empty |-> (wr_ptr_q == rd_ptr_q), "queue pointers skewed")

endmodule

[rtl/spbfb_back.sv]
// Back end: frame store memory, clear sweep, read-modify-write and result register.
`include "sprite_blit_page_framebuffer_macros.svh"

module spbfb_back #(
	parameter int FRAME_BYTES = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spbfb_pkg::q_status_t q_stat,
	input  spbfb_pkg::q_entry_t  head,
	output logic                 pop,
	output logic                 init_busy,
	output logic                 out_valid,
	input  logic                 out_ready,
	output spbfb_pkg::res_t      out_data
);

	localparam int AW = $clog2(FRAME_BYTES);
	localparam logic [AW-1:0] LAST = AW'(FRAME_BYTES - 1);

	spbfb_pkg::bk_state_t state_q;
	spbfb_pkg::bk_state_t state_d;

	logic [7:0]          mem_q [FRAME_BYTES];
	logic [7:0]          rdata_q;
	logic [AW-1:0]       cnt_q;
	spbfb_pkg::q_entry_t cur_q;
	logic                out_valid_q;
	spbfb_pkg::res_t     out_q;

	logic            slot_free;
	logic            mem_we;
	logic [AW-1:0]   mem_addr;
	logic [7:0]      mem_wdata;
	logic            res_load;
	spbfb_pkg::res_t res_val;
	logic            sweep_end;

	assign slot_free = !out_valid_q || out_ready;
	assign pop       = (state_q == spbfb_pkg::BK_IDLE) && !q_stat.empty && slot_free;
	assign init_busy = state_q == spbfb_pkg::BK_INIT;
	assign sweep_end = cnt_q == LAST;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spbfb_pkg::BK_INIT: begin
				if (sweep_end) begin
					state_d = spbfb_pkg::BK_IDLE;
				end
			end
			spbfb_pkg::BK_IDLE: begin
				if (pop) begin
					unique case (head.cmd)
						spbfb_pkg::CMD_CLEAR: state_d = spbfb_pkg::BK_CLEAR;
						spbfb_pkg::CMD_BLIT:  state_d = spbfb_pkg::BK_WR_LO;
						spbfb_pkg::CMD_READ:  state_d = spbfb_pkg::BK_READ;
						default:              state_d = spbfb_pkg::BK_IDLE;
					endcase
				end
			end
			spbfb_pkg::BK_CLEAR: begin
				if (sweep_end) begin
					state_d = spbfb_pkg::BK_IDLE;
				end
			end
			spbfb_pkg::BK_READ: state_d = spbfb_pkg::BK_IDLE;
			spbfb_pkg::BK_WR_LO: begin
				state_d = cur_q.spill ? spbfb_pkg::BK_RD_HI : spbfb_pkg::BK_IDLE;
			end
			spbfb_pkg::BK_RD_HI: state_d = spbfb_pkg::BK_WR_HI;
			spbfb_pkg::BK_WR_HI: state_d = spbfb_pkg::BK_IDLE;
			default: state_d = spbfb_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = head.addr[AW-1:0];
		mem_wdata = '0;
		res_load  = 1'b0;
		res_val   = '0;
		unique case (state_q)
			spbfb_pkg::BK_INIT: begin
				mem_we   = 1'b1;
				mem_addr = cnt_q;
			end
			spbfb_pkg::BK_IDLE: begin
				if (pop && head.cmd == spbfb_pkg::CMD_NOP) begin
					res_load        = 1'b1;
					res_val.clipped = head.clipped;
				end
			end
			spbfb_pkg::BK_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = cnt_q;
				res_load = sweep_end;
			end
			spbfb_pkg::BK_READ: begin
				res_load          = 1'b1;
				res_val.read_data = rdata_q;
			end
			spbfb_pkg::BK_WR_LO: begin
				mem_we    = 1'b1;
				mem_addr  = cur_q.addr[AW-1:0];
				mem_wdata = rdata_q | cur_q.data_lo;
				res_load  = !cur_q.spill;
			end
			spbfb_pkg::BK_RD_HI: begin
				mem_addr = cur_q.addr_hi[AW-1:0];
			end
			spbfb_pkg::BK_WR_HI: begin
				mem_we    = 1'b1;
				mem_addr  = cur_q.addr_hi[AW-1:0];
				mem_wdata = rdata_q | cur_q.data_hi;
				res_load  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spbfb_pkg::BK_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == spbfb_pkg::BK_INIT || state_q == spbfb_pkg::BK_CLEAR) begin
				cnt_q <= sweep_end ? '0 : cnt_q + AW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (res_load) begin
			out_q <= res_val;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_addr];
	end

	`SPBFB_NEVER(a_out_overrun, res_load && out_valid_q && !out_ready, "result overwritten")
	`SPBFB_ASSERT(a_hi_needs_spill, state_q == spbfb_pkg::BK_RD_HI |-> cur_q.spill, "bad spill")
	`SPBFB_ASSERT(a_wr_is_blit, state_q == spbfb_pkg::BK_WR_LO |-> cur_q.cmd == spbfb_pkg::CMD_BLIT, "write without blit")
	`SPBFB_NEVER(a_no_pop_init, pop && init_busy, "command taken during init sweep")

endmodule

[rtl/sprite_blit_page_framebuffer.sv]
// Top level: page framebuffer with sprite blitter, front end, queue and store sequencer.
// The single store port does read then write, so the store sequencer takes a new command
// from the queue only once it is idle again after the previous one.
// Reset: async, active low; afterwards a sweep zeroes the store with in_ready held low.
module sprite_blit_page_framebuffer #(
	parameter int FRAME_BYTES     = 1024,
	parameter int DISPLAY_COLUMNS = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  spbfb_pkg::req_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output spbfb_pkg::res_t out_data
);

	spbfb_pkg::q_status_t q_stat;
	spbfb_pkg::q_entry_t  push_data;
	spbfb_pkg::q_entry_t  head;
	logic                 push;
	logic                 pop;
	logic                 init_busy;

	spbfb_front #(
		.FRAME_BYTES    (FRAME_BYTES),
		.DISPLAY_COLUMNS(DISPLAY_COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (init_busy),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_data(push_data)
	);

	spbfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	spbfb_back #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head     (head),
		.pop      (pop),
		.init_busy(init_busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
